>>> rtl/core/pic_pkg.sv
// Shared types, codes and constants of the eight-line interrupt controller.
package pic_pkg;

    // Operation codes carried by one command item
    typedef enum logic [2:0] {
        OP_READ_CMD  = 3'd0,
        OP_READ_DATA = 3'd1,
        OP_WRITE_CMD = 3'd2,
        OP_WRITE_DATA = 3'd3,
        OP_RAISE     = 3'd4,
        OP_ACK       = 3'd5
    } op_t;

    // Codes with no defined operation; they change nothing
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Initialization sequence position; the data word to come next
    localparam logic [2:0] STEP_ICW2 = 3'd2;
    localparam logic [2:0] STEP_ICW3 = 3'd3;
    localparam logic [2:0] STEP_ICW4 = 3'd4;
    localparam logic [2:0] STEP_DONE = 3'd5;
    localparam logic [2:0] STEP_ICW1 = 3'd1;

    localparam logic [7:0] ICW1_FLAG = 8'h10;
    localparam logic [7:0] OCW3_MASK = 8'h98;
    localparam logic [7:0] OCW3_CODE = 8'h08;
    localparam logic [7:0] EOI_FLAG  = 8'h20;

    // ICW1 bit that selects single mode (no ICW3)
    localparam int SNGL_BIT = 1;
    // OCW3 read-register and read-in-service bits
    localparam int RR_BIT  = 1;
    localparam int RIS_BIT = 0;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_data;
        logic [2:0] request_line;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       vector_valid;
        logic       line1_wait_flag;
        logic       line1_eoi_pulse;
        logic       request_pending;
    } res_t;

    // Isolate the lowest set bit of a byte
    function automatic logic [7:0] lowest_onehot(input logic [7:0] v);
        lowest_onehot = v & (~v + 8'd1);
    endfunction

    // Encode a one-hot byte into its line number
    function automatic logic [2:0] onehot_index(input logic [7:0] oh);
        logic [2:0] idx;
        idx = '0;
        for (int i = 0; i < 8; i++) begin
            if (oh[i]) begin
                idx = idx | 3'(i);
            end
        end
        onehot_index = idx;
    endfunction

endpackage

>>> rtl/core/pic_in_stage.sv
// Input register stage: hold one accepted command item.
module pic_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  pic_pkg::cmd_t cmd,
    input  logic          advance,
    output logic          held_valid,
    output pic_pkg::cmd_t held_item
);

    logic          valid_reg;
    logic          valid_next;
    pic_pkg::cmd_t item_reg;

    // Take a new item when empty or when the held one moves on this cycle
    assign cmd_ready  = !valid_reg || advance;
    assign valid_next = cmd_valid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

>>> rtl/core/pic_core.sv
// Controller state and the single-pass update for one command item.
module pic_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  pic_pkg::cmd_t item,
    output pic_pkg::res_t result
);

    logic [7:0] request_reg, request_next;
    logic [7:0] in_service_reg, in_service_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] base_reg, base_next;
    logic       single_reg, single_next;
    logic [2:0] step_reg, step_next;
    logic       ris_reg, ris_next;
    logic       wait_reg, wait_next;

    logic [2:0] step_eff;
    logic [7:0] pend;
    logic [7:0] pend_low;
    logic [7:0] isr_low;
    logic [7:0] line_bit;

    assign pend     = request_reg & ~mask_reg;
    assign pend_low = pic_pkg::lowest_onehot(pend);
    assign isr_low  = pic_pkg::lowest_onehot(in_service_reg);
    assign line_bit = 8'd1 << item.request_line;

    // Single mode skips ICW3
    always_comb
    begin
        step_eff = step_reg;
        if (step_reg == pic_pkg::STEP_ICW3 && single_reg)
        begin
            step_eff = pic_pkg::STEP_ICW4;
        end
    end

    always_comb
    begin
        request_next    = request_reg;
        in_service_next = in_service_reg;
        mask_next       = mask_reg;
        base_next       = base_reg;
        single_next     = single_reg;
        step_next       = step_reg;
        ris_next        = ris_reg;
        wait_next       = wait_reg;
        result          = '0;

        unique case (pic_pkg::op_t'(item.operation))
            pic_pkg::OP_READ_CMD:
            begin
                result.read_data = ris_reg ? in_service_reg : request_reg;
            end
            pic_pkg::OP_READ_DATA:
            begin
                result.read_data = mask_reg;
            end
            pic_pkg::OP_WRITE_CMD:
            begin
                if ((item.write_data & pic_pkg::ICW1_FLAG) != 8'd0)
                begin
                    // Start initialization; nothing else on this byte
                    mask_next   = '0;
                    single_next = item.write_data[pic_pkg::SNGL_BIT];
                    step_next   = pic_pkg::STEP_ICW2;
                end
                else
                begin
                    if ((item.write_data & pic_pkg::OCW3_MASK) == pic_pkg::OCW3_CODE
                        && item.write_data[pic_pkg::RR_BIT])
                    begin
                        ris_next = item.write_data[pic_pkg::RIS_BIT];
                    end
                    if ((item.write_data & pic_pkg::EOI_FLAG) != 8'd0)
                    begin
                        wait_next              = 1'b0;
                        in_service_next        = in_service_reg & ~isr_low;
                        result.line1_eoi_pulse = isr_low[1];
                    end
                end
            end
            pic_pkg::OP_WRITE_DATA:
            begin
                if (step_eff < pic_pkg::STEP_DONE)
                begin
                    if (step_eff == pic_pkg::STEP_ICW1)
                    begin
                        single_next = item.write_data[pic_pkg::SNGL_BIT];
                    end
                    if (step_eff == pic_pkg::STEP_ICW2)
                    begin
                        base_next = item.write_data;
                    end
                    step_next = step_eff + 3'd1;
                end
                else
                begin
                    step_next = step_eff;
                    mask_next = item.write_data;
                end
            end
            pic_pkg::OP_RAISE:
            begin
                request_next = request_reg | line_bit;
                if (line_bit[1])
                begin
                    wait_next = 1'b1;
                end
            end
            pic_pkg::OP_ACK:
            begin
                if (pend != 8'd0)
                begin
                    request_next        = request_reg & ~pend_low;
                    in_service_next     = in_service_reg | pend_low;
                    result.vector       = base_reg + {5'd0, pic_pkg::onehot_index(pend_low)};
                    result.vector_valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        result.line1_wait_flag = wait_next;
        result.request_pending = (request_next & ~mask_next) != 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_reg    <= '0;
            in_service_reg <= '0;
            mask_reg       <= '0;
            base_reg       <= '0;
            single_reg     <= 1'b0;
            step_reg       <= '0;
            ris_reg        <= 1'b0;
            wait_reg       <= 1'b0;
        end
        else if (fire)
        begin
            request_reg    <= request_next;
            in_service_reg <= in_service_next;
            mask_reg       <= mask_next;
            base_reg       <= base_next;
            single_reg     <= single_next;
            step_reg       <= step_next;
            ris_reg        <= ris_next;
            wait_reg       <= wait_next;
        end
    end

endmodule

>>> rtl/core/pic_out_stage.sv
// Result register stage: hold one finished result item until taken.
module pic_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  pic_pkg::res_t result,
    output logic          space,
    output logic          res_valid,
    input  logic          res_ready,
    output pic_pkg::res_t res
);

    logic          valid_reg;
    logic          valid_next;
    pic_pkg::res_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign space      = !valid_reg || res_ready;
    assign valid_next = load || (valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

    assign res_valid = valid_reg;
    assign res       = item_reg;

endmodule

>>> rtl/core/interrupt_controller_8259.sv
// Top level of the eight-line prioritized interrupt controller.
// An accepted item is registered in the input stage, then moves into the result
// register when that has room, and shows on res from there.
// Throughput: one item per cycle while the consumer takes results, set by the single-pass state update in pic_core.
// Reset: rst_n clears request, in-service and mask registers, the init sequence,
// the read select, the line 1 wait flag and both stage valid bits at once.
// The first data write after reset lands as init word 0.
module interrupt_controller_8259 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  pic_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output pic_pkg::res_t res
);

    logic          held_valid;
    pic_pkg::cmd_t held_item;
    logic          space;
    logic          fire;
    pic_pkg::res_t result;

    // Advance the held item into the result register whenever there is room;
    // the controller state updates on that same edge, so the next item sees it.
    assign fire = held_valid && space;

    pic_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .advance    (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Register file plus priority logic: one item's full effect in one pass
    pic_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (held_item),
        .result (result)
    );

    // Result register parts the consumer's stall from the input side
    pic_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .space     (space),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
